@@ src/rrtp_pkg.sv @@
// Shared widths, register codes, reset values and control types for the tip pulse generator.
package rrtp_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int NUM_W      = 32;
  localparam int RATE_W     = 16;
  localparam int HOLD_W     = 20;
  localparam int PW_W       = 16;
  localparam int TPS_W      = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_S = 2'd2;

  localparam logic [PW_W-1:0]  PULSE_WIDTH_RST = 16'd50;
  localparam logic [NUM_W-1:0] NUMERATOR_RST   = 32'd91440000;
  localparam logic [TPS_W-1:0] TICKS_PER_S_RST = 16'd1000;

  typedef struct packed {
    logic tick_exec;
    logic load_start;
    logic div_step;
    logic load_finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } ctl_status_t;

endpackage

@@ src/rrtp_in_if.sv @@
// Input channel: tick or record load beats.
interface rrtp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] rain_rate;
  logic [19:0] hold_seconds;

  modport source (output valid, output action, output rain_rate, output hold_seconds,
                  input ready);
  modport sink   (input valid, input action, input rain_rate, input hold_seconds,
                  output ready);
endinterface

@@ src/rrtp_out_if.sv @@
// Output channel: one switch status beat per input beat.
interface rrtp_out_if;
  logic valid;
  logic ready;
  logic switch_active;
  logic tip_started;
  logic record_expired;

  modport source (output valid, output switch_active, output tip_started,
                  output record_expired, input ready);
  modport sink   (input valid, input switch_active, input tip_started,
                  input record_expired, output ready);
endinterface

@@ src/rain_rate_tip_pulse_generator_top.sv @@
// Top level of the tipping-bucket rain gauge switch emulator.
//
//   Channel   Dir  Payload                                   Handshake
//   in_ch     in   action, rain_rate, hold_seconds           valid/ready
//   out_ch    out  switch_active, tip_started, record_expired valid/ready
//   cfg       in   cfg_index, cfg_data                       cfg_we, no stall
//
// A tick beat's result is registered at the accepting edge.
// A load beat is captured, the interval numerator is then divided bit-serially by the
// rain rate, and finally the new record is applied.
// Input ready is high only in idle while the result register is free or being taken.
// A stalled output therefore holds off further input beats; reset is synchronous.
module rain_rate_tip_pulse_generator_top (
  input  logic                            clk,
  input  logic                            rst,
  rrtp_in_if.sink                         in_ch,
  rrtp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rrtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrtp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rrtp_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  rrtp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rrtp_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_rain_rate       (in_ch.rain_rate),
    .in_hold_seconds    (in_ch.hold_seconds),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_switch_active  (out_ch.switch_active),
    .out_tip_started    (out_ch.tip_started),
    .out_record_expired (out_ch.record_expired)
  );

endmodule

@@ src/rrtp_ctrl.sv @@
// Controller state machine: sequences ticks, the interval division and record loads.
module rrtp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_ready,
  input  rrtp_pkg::ctl_status_t status,
  output rrtp_pkg::ctl_cmd_t    cmd
);
  import rrtp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && !status.out_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_action) begin
          cmd.load_start = 1'b1;
          state_next     = ST_DIV;
        end else if (accept) begin
          cmd.tick_exec = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.load_finish = 1'b1;
        state_next      = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("input ready outside idle");

  a_load_enters_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load_start |=> state == ST_DIV)
    else $error("load beat did not start the division");

  a_finish_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load_finish |-> $past(state == ST_DIV))
    else $error("load finished without a division");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one command at once");

endmodule

@@ src/rrtp_datapath.sv @@
// Datapath: configuration registers, restoring divider, tip and hold counters, result register.
module rrtp_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  rrtp_pkg::ctl_cmd_t                 cmd,
  output rrtp_pkg::ctl_status_t              status,
  input  logic                               cfg_we,
  input  logic [rrtp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrtp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [rrtp_pkg::RATE_W-1:0]        in_rain_rate,
  input  logic [rrtp_pkg::HOLD_W-1:0]        in_hold_seconds,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_switch_active,
  output logic                               out_tip_started,
  output logic                               out_record_expired
);
  import rrtp_pkg::*;

  localparam int QW = (TIME_WIDTH > NUM_W) ? TIME_WIDTH : NUM_W;
  localparam logic [QW-1:0] TIME_MAX_EXT = QW'({TIME_WIDTH{1'b1}});

  // Configuration registers.
  logic [PW_W-1:0]  pulse_width_ticks;
  logic [NUM_W-1:0] interval_numerator;
  logic [TPS_W-1:0] ticks_per_second;

  // Record state.
  logic [TIME_WIDTH-1:0] tip_interval, tip_interval_next;
  logic [TIME_WIDTH-1:0] interval_countdown, interval_countdown_next;
  logic [PW_W-1:0]       pulse_remaining, pulse_remaining_next;
  logic [HOLD_W-1:0]     seconds_left, seconds_left_next;
  logic [TPS_W-1:0]      subsecond_count, subsecond_count_next;
  logic                  record_running, record_running_next;
  logic                  tipped, expired;

  // Divider.
  logic [RATE_W-1:0]    rate_q;
  logic [HOLD_W-1:0]    hold_q;
  logic [NUM_W-1:0]     quot;
  logic [RATE_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] div_count;
  logic [RATE_W:0]      rem_shift;
  logic                 rem_ge;
  logic [RATE_W:0]      rem_diff;

  logic [QW-1:0]         q_ext;
  logic [TIME_WIDTH-1:0] q_fixed;

  logic [TPS_W:0]        sub_inc;
  logic [TIME_WIDTH-1:0] cd_dec;

  assign status.div_last = div_count == DIV_CNT_W'(DIV_STEPS - 1);
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width_ticks  <= PULSE_WIDTH_RST;
      interval_numerator <= NUMERATOR_RST;
      ticks_per_second   <= TICKS_PER_S_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_WIDTH: pulse_width_ticks  <= cfg_data[PW_W-1:0];
        CFG_NUMERATOR:   interval_numerator <= cfg_data[NUM_W-1:0];
        CFG_TICKS_PER_S: ticks_per_second   <= cfg_data[TPS_W-1:0];
        default: ;
      endcase
    end
  end

  // One quotient bit per cycle, remainder kept below the divisor.
  assign rem_shift = {rem, quot[NUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, rate_q};
  assign rem_diff  = rem_shift - {1'b0, rate_q};

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      rate_q    <= in_rain_rate;
      hold_q    <= in_hold_seconds;
      quot      <= interval_numerator;
      rem       <= '0;
      div_count <= '0;
    end else if (cmd.div_step) begin
      quot      <= {quot[NUM_W-2:0], rem_ge};
      rem       <= rem_ge ? rem_diff[RATE_W-1:0] : rem_shift[RATE_W-1:0];
      div_count <= div_count + 1'b1;
    end
  end

  always_comb begin
    q_ext = QW'(quot);
    if (q_ext > TIME_MAX_EXT) begin
      q_fixed = TIME_WIDTH'(TIME_MAX_EXT);
    end else if (q_ext == '0) begin
      q_fixed = TIME_WIDTH'(1);
    end else begin
      q_fixed = TIME_WIDTH'(q_ext);
    end
  end

  assign sub_inc = {1'b0, subsecond_count} + 1'b1;
  assign cd_dec  = (interval_countdown != '0) ? interval_countdown - 1'b1 : interval_countdown;

  always_comb begin
    tip_interval_next       = tip_interval;
    interval_countdown_next = interval_countdown;
    pulse_remaining_next    = pulse_remaining;
    seconds_left_next       = seconds_left;
    subsecond_count_next    = subsecond_count;
    record_running_next     = record_running;
    tipped                  = 1'b0;
    expired                 = 1'b0;

    if (cmd.load_finish) begin
      if (rate_q == '0) begin
        tip_interval_next       = '0;
        interval_countdown_next = '0;
      end else begin
        tip_interval_next       = q_fixed;
        interval_countdown_next = q_fixed;
        pulse_remaining_next    = pulse_width_ticks;
        tipped                  = 1'b1;
      end
      seconds_left_next    = hold_q;
      subsecond_count_next = '0;
      record_running_next  = 1'b1;
    end else if (cmd.tick_exec) begin
      if (pulse_remaining != '0) begin
        pulse_remaining_next = pulse_remaining - 1'b1;
      end
      if (tip_interval != '0) begin
        interval_countdown_next = cd_dec;
        if (cd_dec == '0) begin
          pulse_remaining_next    = pulse_width_ticks;
          tipped                  = 1'b1;
          interval_countdown_next = tip_interval;
        end
      end
      if (record_running) begin
        if (seconds_left != '0) begin
          // A zero ticks-per-second setting wraps every tick, as a setting of one does.
          if (sub_inc >= {1'b0, ticks_per_second}) begin
            subsecond_count_next = '0;
            seconds_left_next    = seconds_left - 1'b1;
          end else begin
            subsecond_count_next = sub_inc[TPS_W-1:0];
          end
        end
        if (seconds_left_next == '0) begin
          record_running_next  = 1'b0;
          subsecond_count_next = '0;
          expired              = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tip_interval       <= '0;
      interval_countdown <= '0;
      pulse_remaining    <= '0;
      seconds_left       <= '0;
      subsecond_count    <= '0;
      record_running     <= 1'b0;
    end else begin
      tip_interval       <= tip_interval_next;
      interval_countdown <= interval_countdown_next;
      pulse_remaining    <= pulse_remaining_next;
      seconds_left       <= seconds_left_next;
      subsecond_count    <= subsecond_count_next;
      record_running     <= record_running_next;
    end
  end

  // Result register; the controller only issues a result when it is free or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.tick_exec || cmd.load_finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_exec || cmd.load_finish) begin
      out_switch_active  <= pulse_remaining_next != '0;
      out_tip_started    <= tipped;
      out_record_expired <= expired;
    end
  end

endmodule

@@ dv/rain_rate_tip_pulse_generator_top_tb.sv @@
// Self-checking testbench: predicts the switch, tip and expiry flags for every tick and record load.
`timescale 1ns / 100ps

module rain_rate_tip_pulse_generator_top_tb;
  import rrtp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BEATS_PER_SETTING = 225;
  localparam int MAX_ERR_LINES = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ACT_TICK = 1'b0, ACT_LOAD = 1'b1} action_t;
  typedef enum logic {ROW_BEAT = 1'b0, ROW_REG = 1'b1} row_kind_t;

  typedef struct packed {
    logic switch_active;
    logic tip_started;
    logic record_expired;
  } gauge_status_t;

  // For a register row arg_a is the index and arg_b the data; for a beat, rate and hold.
  typedef struct {
    row_kind_t     kind;
    action_t       act;
    logic [31:0]   arg_a;
    logic [31:0]   arg_b;
    bit            typed;
    gauge_status_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rrtp_in_if  in_ch();
  rrtp_out_if out_ch();

  rain_rate_tip_pulse_generator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Register copies and gauge state of the predictor.
  logic [PW_W-1:0]       width_cfg;
  logic [NUM_W-1:0]      numer_cfg;
  logic [TPS_W-1:0]      tps_cfg;
  logic [TIME_WIDTH-1:0] tip_gap;
  logic [TIME_WIDTH-1:0] gap_left;
  logic [PW_W-1:0]       pulse_left;
  logic [HOLD_W-1:0]     secs_left;
  logic [TPS_W-1:0]      sub_ticks;
  bit                    record_live;

  gauge_status_t pending_status[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  int unsigned err_count;
  int unsigned beats_sent;
  int unsigned loads_sent;
  int unsigned results_seen;
  int unsigned tips_seen;
  int unsigned expiries_seen;

  function automatic gauge_status_t advance_gauge(action_t act, logic [RATE_W-1:0] rate,
                                                  logic [HOLD_W-1:0] hold);
    logic [NUM_W-1:0] quot;
    logic [TPS_W:0]   nxt;
    gauge_status_t    res;
    res = '0;
    if (act == ACT_LOAD) begin
      if (rate == '0) begin
        tip_gap = '0;
      end else begin
        // A 32-bit numerator over a rate of at least one always fits TIME_WIDTH.
        quot = numer_cfg / NUM_W'(rate);
        if (quot == '0) quot = 1;
        tip_gap = TIME_WIDTH'(quot);
      end
      gap_left = tip_gap;
      if (rate != '0) begin
        pulse_left = width_cfg;
        res.tip_started = 1'b1;
      end
      secs_left = hold;
      sub_ticks = '0;
      record_live = 1'b1;
    end else begin
      if (pulse_left != '0) pulse_left = pulse_left - 1'b1;
      if (tip_gap != '0) begin
        if (gap_left != '0) gap_left = gap_left - 1'b1;
        if (gap_left == '0) begin
          pulse_left = width_cfg;
          res.tip_started = 1'b1;
          gap_left = tip_gap;
        end
      end
      if (record_live) begin
        if (secs_left != '0) begin
          // A ticks-per-second setting of zero behaves as a setting of one.
          nxt = {1'b0, sub_ticks} + 1'b1;
          if (nxt >= {1'b0, tps_cfg}) begin
            sub_ticks = '0;
            secs_left = secs_left - 1'b1;
          end else begin
            sub_ticks = nxt[TPS_W-1:0];
          end
        end
        if (secs_left == '0) begin
          record_live = 1'b0;
          sub_ticks = '0;
          res.record_expired = 1'b1;
        end
      end
    end
    res.switch_active = (pulse_left != '0);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_ERR_LINES) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : status_monitor
    gauge_status_t got;
    gauge_status_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.switch_active, out_ch.tip_started, out_ch.record_expired};
      results_seen++;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("result beat %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_status.pop_front();
        if (got.switch_active !== want.switch_active)
          report_mismatch($sformatf("beat %0d switch_active got %b want %b", results_seen,
                                    got.switch_active, want.switch_active));
        if (got.tip_started !== want.tip_started)
          report_mismatch($sformatf("beat %0d tip_started got %b want %b", results_seen,
                                    got.tip_started, want.tip_started));
        if (got.record_expired !== want.record_expired)
          report_mismatch($sformatf("beat %0d record_expired got %b want %b", results_seen,
                                    got.record_expired, want.record_expired));
        if (got.tip_started === 1'b1) tips_seen++;
        if (got.record_expired === 1'b1) expiries_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               pending_status.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic drive_beat(input action_t act, input logic [RATE_W-1:0] rate,
                            input logic [HOLD_W-1:0] hold, input bit typed,
                            input gauge_status_t typed_want);
    gauge_status_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.rain_rate    <= rate;
    in_ch.hold_seconds <= hold;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = advance_gauge(act, rate, hold);
    pending_status.push_back(typed ? typed_want : predicted);
    beats_sent++;
    if (act == ACT_LOAD) loads_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_status.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      CFG_PULSE_WIDTH: width_cfg = data[PW_W-1:0];
      CFG_NUMERATOR:   numer_cfg = data[NUM_W-1:0];
      CFG_TICKS_PER_S: tps_cfg   = data[TPS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic change_setting(input logic [31:0] pw, input logic [31:0] numer,
                                input logic [31:0] tps);
    wait_for_results();
    repeat (2) @(negedge clk);
    write_reg(CFG_PULSE_WIDTH, pw);
    write_reg(CFG_NUMERATOR, numer);
    write_reg(CFG_TICKS_PER_S, tps);
  endtask

  // Mostly whole records: a load followed by enough ticks to see tips and, often, the expiry.
  task automatic run_random_setting(input int unsigned quota);
    int unsigned       start;
    int unsigned       pick;
    int unsigned       span;
    longint unsigned   budget;
    logic [NUM_W-1:0]  quot;
    logic [RATE_W-1:0] rate;
    logic [HOLD_W-1:0] hold;
    start = beats_sent;
    while (beats_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        drive_beat(action_t'($urandom_range(1)), RATE_W'($urandom), HOLD_W'($urandom),
                   1'b0, '0);
      end else begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          rate = '0;
        end else if (pick < 35) begin
          rate = RATE_W'($urandom_range(1, 65535));
        end else begin
          quot = numer_cfg / NUM_W'($urandom_range(1, 24));
          rate = (quot > 65535) ? 16'hFFFF : (quot == '0) ? 16'd1 : RATE_W'(quot);
        end
        pick = $urandom_range(99);
        if (pick < 10) hold = HOLD_W'($urandom);
        else if (pick < 25) hold = '0;
        else hold = HOLD_W'($urandom_range(1, 4));
        drive_beat(ACT_LOAD, rate, hold, 1'b0, '0);
        budget = longint'(hold) * longint'((tps_cfg == '0) ? 1 : tps_cfg);
        span = (budget > 34) ? 40 : int'(budget) + 6;
        repeat ($urandom_range(0, span))
          drive_beat(ACT_TICK, RATE_W'($urandom), HOLD_W'($urandom), 1'b0, '0);
      end
      if ($urandom_range(49) == 0) wait_for_results();
    end
  endtask

  function automatic stim_row_t beat_row(action_t act, logic [31:0] rate, logic [31:0] hold,
                                         bit typed, logic [2:0] want);
    stim_row_t r;
    r.kind  = ROW_BEAT;
    r.act   = act;
    r.arg_a = rate;
    r.arg_b = hold;
    r.typed = typed;
    r.want  = gauge_status_t'(want);
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    stim_row_t r;
    r = beat_row(ACT_TICK, 32'(idx), data, 1'b0, 3'b000);
    r.kind = ROW_REG;
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_TICK;
    in_ch.rain_rate    = '0;
    in_ch.hold_seconds = '0;
    send_idle_pct      = 12;
    recv_idle_pct      = 52;
    width_cfg          = PULSE_WIDTH_RST;
    numer_cfg          = NUMERATOR_RST;
    tps_cfg            = TICKS_PER_S_RST;
    tip_gap            = '0;
    gap_left           = '0;
    pulse_left         = '0;
    secs_left          = '0;
    sub_ticks          = '0;
    record_live        = 1'b0;

    // Typed results are {switch_active, tip_started, record_expired}.
    rows.push_back(beat_row(ACT_TICK, 32'hFFFF, 32'hFFFFF, 1'b1, 3'b000));
    rows.push_back(beat_row(ACT_LOAD, 0, 0, 1'b1, 3'b000));
    rows.push_back(beat_row(ACT_TICK, 0, 0, 1'b1, 3'b001));
    rows.push_back(beat_row(ACT_TICK, 0, 0, 1'b1, 3'b000));
    rows.push_back(beat_row(ACT_LOAD, 32'hFFFF, 32'hFFFFF, 1'b1, 3'b110));
    rows.push_back(beat_row(ACT_LOAD, 1, 1, 1'b1, 3'b110));
    // A dry load leaves the running pulse alone.
    rows.push_back(beat_row(ACT_LOAD, 0, 0, 1'b1, 3'b100));
    rows.push_back(beat_row(ACT_TICK, 0, 0, 1'b1, 3'b101));
    rows.push_back(reg_row(CFG_PULSE_WIDTH, 32'hABCD_0002));
    rows.push_back(reg_row(CFG_UNUSED, 32'hFFFF_FFFF));
    rows.push_back(reg_row(CFG_NUMERATOR, 32'd1));
    rows.push_back(reg_row(CFG_TICKS_PER_S, 32'd0));
    // The quotient rounds up to one tick, so every tick re-arms the pulse.
    rows.push_back(beat_row(ACT_LOAD, 2, 1, 1'b1, 3'b110));
    rows.push_back(beat_row(ACT_TICK, 0, 0, 1'b1, 3'b111));
    rows.push_back(beat_row(ACT_TICK, 0, 0, 1'b1, 3'b110));
    rows.push_back(reg_row(CFG_PULSE_WIDTH, 32'd0));
    rows.push_back(beat_row(ACT_LOAD, 32'hFFFF, 2, 1'b1, 3'b010));
    rows.push_back(beat_row(ACT_TICK, 0, 0, 1'b1, 3'b010));
    rows.push_back(beat_row(ACT_TICK, 0, 0, 1'b1, 3'b011));
    rows.push_back(reg_row(CFG_PULSE_WIDTH, 32'hFFFF));
    rows.push_back(reg_row(CFG_NUMERATOR, 32'hFFFF_FFFF));
    rows.push_back(reg_row(CFG_TICKS_PER_S, 32'hFFFF));
    rows.push_back(beat_row(ACT_LOAD, 1, 3, 1'b1, 3'b110));
    rows.push_back(beat_row(ACT_TICK, 0, 0, 1'b1, 3'b100));
    rows.push_back(beat_row(ACT_LOAD, 32'h5555, 32'hAAAAA, 1'b0, 3'b000));
    rows.push_back(beat_row(ACT_TICK, 32'hAAAA, 32'h55555, 1'b0, 3'b000));
    rows.push_back(beat_row(ACT_LOAD, 32'hAAAA, 32'h55555, 1'b0, 3'b000));
    rows.push_back(beat_row(ACT_TICK, 32'h5555, 32'hAAAAA, 1'b0, 3'b000));

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        wait_for_results();
        repeat (2) @(negedge clk);
        write_reg(rows[i].arg_a[CFG_IDX_W-1:0], rows[i].arg_b);
      end else begin
        drive_beat(rows[i].act, rows[i].arg_a[RATE_W-1:0], rows[i].arg_b[HOLD_W-1:0],
                   rows[i].typed, rows[i].want);
      end
    end

    change_setting(32'd3, 32'd300, 32'd2);
    run_random_setting(BEATS_PER_SETTING);
    change_setting(32'd1, 32'd1, 32'd1);
    run_random_setting(BEATS_PER_SETTING);

    send_idle_pct = 52;
    recv_idle_pct = 12;
    change_setting(32'd7, 32'd5000, 32'd3);
    run_random_setting(BEATS_PER_SETTING);
    change_setting(32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF);
    run_random_setting(BEATS_PER_SETTING);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    change_setting(32'd0, 32'd91440000, 32'd0);
    run_random_setting(BEATS_PER_SETTING);
    change_setting(32'd20, 32'd1000, 32'd4);
    run_random_setting(BEATS_PER_SETTING);

    wait_for_results();
    repeat (40) @(negedge clk);

    $display("Drove %0d beats, %0d of them record loads, across ten register settings.",
             beats_sent, loads_sent);
    $display("Checked %0d result beats: %0d tip starts, %0d record expiries, %0d mismatches.",
             results_seen, tips_seen, expiries_seen, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
